/* src/tcw_pkg.sv */
// Shared types and constants for the text console cell writer.
package tcw_pkg;

  // Fixed port widths
  localparam int ROW_PORT_W = 5;
  localparam int COL_PORT_W = 7;
  localparam int CHAR_W     = 8;
  localparam int ATTR_W     = 8;
  localparam int CELL_W     = CHAR_W + ATTR_W;

  // Attribute after reset
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd15;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NEWLINE  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN   = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7E;

  // Command codes
  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;    // capture the input beat
    logic exec;    // run the put or issue the cell read
    logic sweep;   // write zero at the clear pointer and advance it
    logic rd_out;  // capture read data into the result
  } tcw_ctrl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_read;     // captured beat is a read
    logic scroll;      // this put pushes the cursor past the bottom row
    logic sweep_last;  // clear pointer sits on the last cell of the sweep
  } tcw_stat_t;

endpackage

/* src/tcw_ctrl.sv */
// Sequencing state machine for the text console cell writer.
module tcw_ctrl import tcw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  tcw_stat_t stat,
  output tcw_ctrl_t ctrl,
  output logic      busy,
  output logic      done
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCROLL
  } state_t;

  state_t state;
  state_t state_next;
  logic   done_next;

  // Decode next state and datapath commands
  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    ctrl       = '0;
    unique case (state)
      ST_CLEAR: begin
        ctrl.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          ctrl.load  = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctrl.exec = 1'b1;
        if (stat.is_read) begin
          state_next = ST_READ;
        end else if (stat.scroll) begin
          state_next = ST_SCROLL;
        end else begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        ctrl.rd_out = 1'b1;
        done_next   = 1'b1;
        state_next  = ST_IDLE;
      end
      ST_SCROLL: begin
        ctrl.sweep = 1'b1;
        if (stat.sweep_last) begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold state and the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

/* src/tcw_datapath.sv */
// Cell store, cursor, scroll offset and result registers of the console.
module tcw_datapath import tcw_pkg::*; #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tcw_ctrl_t             ctrl,
  output tcw_stat_t             stat,
  input  logic                  command,
  input  logic [CHAR_W-1:0]     char_code,
  input  logic [ROW_PORT_W-1:0] read_row,
  input  logic [COL_PORT_W-1:0] read_col,
  input  logic                  cfg_write,
  input  logic [ATTR_W-1:0]     cfg_data,
  output logic                  cell_written,
  output logic [ROW_PORT_W-1:0] written_row,
  output logic [COL_PORT_W-1:0] written_col,
  output logic                  scrolled,
  output logic [ROW_PORT_W-1:0] cursor_row_out,
  output logic [COL_PORT_W-1:0] cursor_col_out,
  output logic [CHAR_W-1:0]     read_char,
  output logic [ATTR_W-1:0]     read_attr
);

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);

  // Logical row to physical row through the ring offset
  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] lrow,
                                             input logic [RW-1:0] top);
    logic [RW:0] sum;
    sum = {1'b0, lrow} + {1'b0, top};
    if (sum >= (RW+1)'(ROWS)) begin
      sum = sum - (RW+1)'(ROWS);
    end
    return sum[RW-1:0];
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] prow,
                                              input logic [CW-1:0] col);
    return AW'(prow) * AW'(COLS) + AW'(col);
  endfunction

  // Captured input beat
  logic                  cmd_q;
  logic [CHAR_W-1:0]     char_q;
  logic [ROW_PORT_W-1:0] rrow_q;
  logic [COL_PORT_W-1:0] rcol_q;

  // Console state
  logic [RW-1:0]     cursor_row;
  logic [CW-1:0]     cursor_col;
  logic [RW-1:0]     top_row;
  logic [ATTR_W-1:0] attr;
  logic [AW-1:0]     clr_addr;
  logic [AW-1:0]     clr_end;

  // Cell store
  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] mem_q;
  logic              rd_ok_q;
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;

  // Put decode
  logic          printable;
  logic [CW:0]   col_inc;
  logic          col_wrap;
  logic          row_adv;
  logic          scroll_hit;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;
  logic [AW-1:0] put_addr;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] top_addr;
  logic          rd_ok;
  logic          do_put;

  assign printable = (char_q >= CH_PRINT_LO) && (char_q <= CH_PRINT_HI);
  assign col_inc   = {1'b0, cursor_col} + (CW+1)'(1);
  assign col_wrap  = (col_inc == (CW+1)'(COLS));
  assign do_put    = ctrl.exec && (cmd_q == CMD_PUT);

  // Work out the cursor move for the captured byte
  always_comb begin
    col_next = cursor_col;
    row_adv  = 1'b0;
    if (char_q == CH_NEWLINE) begin
      col_next = '0;
      row_adv  = 1'b1;
    end else if (char_q == CH_RETURN) begin
      col_next = '0;
    end else if (printable) begin
      if (col_wrap) begin
        col_next = '0;
        row_adv  = 1'b1;
      end else begin
        col_next = col_inc[CW-1:0];
      end
    end
    scroll_hit = row_adv && (cursor_row == RW'(ROWS - 1));
    if (scroll_hit) begin
      row_next = RW'(ROWS - 1);
    end else if (row_adv) begin
      row_next = cursor_row + RW'(1);
    end else begin
      row_next = cursor_row;
    end
  end

  assign put_addr = cell_addr(phys_row(cursor_row, top_row), cursor_col);
  assign rd_addr  = cell_addr(phys_row(RW'(rrow_q), top_row), CW'(rcol_q));
  assign top_addr = cell_addr(top_row, CW'(0));
  assign rd_ok    = (32'(rrow_q) < 32'(ROWS)) && (32'(rcol_q) < 32'(COLS));

  assign stat.is_read    = (cmd_q == CMD_READ);
  assign stat.scroll     = scroll_hit;
  assign stat.sweep_last = (clr_addr == clr_end);

  // Select the store write: clearing sweep or a printed cell
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    if (ctrl.sweep) begin
      mem_we = 1'b1;
    end else if (do_put && printable) begin
      mem_we    = 1'b1;
      mem_waddr = put_addr;
      mem_wdata = {attr, char_q};
    end
  end

  assign mem_re = ctrl.exec && (cmd_q == CMD_READ) && rd_ok;

  // Cell store ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Console control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_row <= '0;
      cursor_col <= '0;
      top_row    <= '0;
      attr       <= ATTR_RESET;
      clr_addr   <= '0;
      clr_end    <= AW'(CELLS - 1);
    end else begin
      if (cfg_write) begin
        attr <= cfg_data;
      end
      if (do_put) begin
        cursor_row <= row_next;
        cursor_col <= col_next;
        if (scroll_hit) begin
          // old top row becomes the new bottom row and gets cleared
          top_row  <= (top_row == RW'(ROWS - 1)) ? '0 : top_row + RW'(1);
          clr_addr <= top_addr;
          clr_end  <= top_addr + AW'(COLS - 1);
        end
      end
      if (ctrl.sweep && !stat.sweep_last) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  // Capture the beat and build the result
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q  <= command;
      char_q <= char_code;
      rrow_q <= read_row;
      rcol_q <= read_col;
    end
    if (ctrl.exec) begin
      rd_ok_q   <= rd_ok;
      read_char <= '0;
      read_attr <= '0;
      if (cmd_q == CMD_PUT) begin
        cell_written   <= printable;
        written_row    <= printable ? ROW_PORT_W'(cursor_row) : '0;
        written_col    <= printable ? COL_PORT_W'(cursor_col) : '0;
        scrolled       <= scroll_hit;
        cursor_row_out <= ROW_PORT_W'(row_next);
        cursor_col_out <= COL_PORT_W'(col_next);
      end else begin
        cell_written   <= 1'b0;
        written_row    <= '0;
        written_col    <= '0;
        scrolled       <= 1'b0;
        cursor_row_out <= ROW_PORT_W'(cursor_row);
        cursor_col_out <= COL_PORT_W'(cursor_col);
      end
    end
    if (ctrl.rd_out) begin
      read_char <= rd_ok_q ? mem_q[CHAR_W-1:0] : '0;
      read_attr <= rd_ok_q ? mem_q[CELL_W-1:CHAR_W] : '0;
    end
  end

endmodule

/* src/text_console_cell_writer.sv */
// Top level of the text console cell writer: controller plus datapath.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-----------------------------------------
//  command   | start / busy         | command, char_code, read_row, read_col
//  result    | done (one cycle)     | cell_written, written_row, written_col,
//            |                      | scrolled, cursor_row_out, cursor_col_out,
//            |                      | read_char, read_attr
//  config    | cfg_write            | cfg_data (text attribute)
//
// A put runs through the exec state before done; a read also passes the read
// state for the registered store read. A put that scrolls then sweeps the
// cleared row cell by cell through the single store write port.
// After reset the store is cleared one cell a cycle, with busy high;
// cfg_write is taken throughout.
// done is high for one cycle per beat and the receiver cannot stall it.
module text_console_cell_writer import tcw_pkg::*; #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  command,
  input  logic [CHAR_W-1:0]     char_code,
  input  logic [ROW_PORT_W-1:0] read_row,
  input  logic [COL_PORT_W-1:0] read_col,
  input  logic                  cfg_write,
  input  logic [ATTR_W-1:0]     cfg_data,
  output logic                  done,
  output logic                  cell_written,
  output logic [ROW_PORT_W-1:0] written_row,
  output logic [COL_PORT_W-1:0] written_col,
  output logic                  scrolled,
  output logic [ROW_PORT_W-1:0] cursor_row_out,
  output logic [COL_PORT_W-1:0] cursor_col_out,
  output logic [CHAR_W-1:0]     read_char,
  output logic [ATTR_W-1:0]     read_attr
);

  tcw_ctrl_t ctrl;
  tcw_stat_t stat;

  tcw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy),
    .done  (done)
  );

  tcw_datapath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .stat           (stat),
    .command        (command),
    .char_code      (char_code),
    .read_row       (read_row),
    .read_col       (read_col),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .cell_written   (cell_written),
    .written_row    (written_row),
    .written_col    (written_col),
    .scrolled       (scrolled),
    .cursor_row_out (cursor_row_out),
    .cursor_col_out (cursor_col_out),
    .read_char      (read_char),
    .read_attr      (read_attr)
  );

  // No result beat straight out of reset
  a_no_done_after_rst: assert property (@(posedge clk) $past(rst) |-> !done)
    else $error("result beat right after reset");

  // An accepted command keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a command");

  // A scroll always leaves the cursor on the bottom row
  a_scroll_bottom: assert property (@(posedge clk) disable iff (rst)
    (done && scrolled) |-> (cursor_row_out == ROW_PORT_W'(ROWS - 1)))
    else $error("scroll left cursor off the bottom row");

  // A printed cell never carries read data
  a_put_no_read: assert property (@(posedge clk) disable iff (rst)
    (done && cell_written) |-> (read_char == '0 && read_attr == '0 && !ctrl.rd_out))
    else $error("read data on a put result");

endmodule

/* bench/text_console_cell_writer_checker.sv */
// Checker for the text console cell writer: console predictor and result compare.
module text_console_cell_writer_checker import tcw_pkg::*; #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  logic                  command,
  input  logic [CHAR_W-1:0]     char_code,
  input  logic [ROW_PORT_W-1:0] read_row,
  input  logic [COL_PORT_W-1:0] read_col,
  input  logic                  cfg_write,
  input  logic [ATTR_W-1:0]     cfg_data,
  input  logic                  done,
  input  logic                  cell_written,
  input  logic [ROW_PORT_W-1:0] written_row,
  input  logic [COL_PORT_W-1:0] written_col,
  input  logic                  scrolled,
  input  logic [ROW_PORT_W-1:0] cursor_row_out,
  input  logic [COL_PORT_W-1:0] cursor_col_out,
  input  logic [CHAR_W-1:0]     read_char,
  input  logic [ATTR_W-1:0]     read_attr,
  output int                    err_count,
  output int                    pending
);

  typedef struct packed {
    logic                  cell_written;
    logic [ROW_PORT_W-1:0] written_row;
    logic [COL_PORT_W-1:0] written_col;
    logic                  scrolled;
    logic [ROW_PORT_W-1:0] cursor_row;
    logic [COL_PORT_W-1:0] cursor_col;
    logic [CHAR_W-1:0]     read_char;
    logic [ATTR_W-1:0]     read_attr;
  } console_result_t;

  // Shadow copy of the console
  logic [CELL_W-1:0] screen_cells [ROWS*COLS];
  int                cur_row;
  int                cur_col;
  int                top_offset;
  logic [ATTR_W-1:0] text_attr;

  console_result_t   console_results_q [$];
  int                errs = 0;

  assign err_count = errs;

  function automatic int cell_index(int logical_row, int col);
    return ((logical_row + top_offset) % ROWS) * COLS + col;
  endfunction

  // Apply one command beat to the shadow console and return its result
  function automatic console_result_t console_step(logic cmd, logic [CHAR_W-1:0] ch,
                                                   logic [ROW_PORT_W-1:0] rrow,
                                                   logic [COL_PORT_W-1:0] rcol);
    console_result_t   res;
    logic [CELL_W-1:0] cell_word;
    res = '0;
    if (cmd == CMD_READ) begin
      if (int'(rrow) < ROWS && int'(rcol) < COLS) begin
        cell_word     = screen_cells[cell_index(int'(rrow), int'(rcol))];
        res.read_char = cell_word[CHAR_W-1:0];
        res.read_attr = cell_word[CELL_W-1:CHAR_W];
      end
    end else begin
      if (ch == CH_NEWLINE) begin
        cur_col = 0;
        cur_row++;
      end else if (ch == CH_RETURN) begin
        cur_col = 0;
      end else if (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI) begin
        screen_cells[cell_index(cur_row, cur_col)] = {text_attr, ch};
        res.cell_written = 1'b1;
        res.written_row  = ROW_PORT_W'(cur_row);
        res.written_col  = COL_PORT_W'(cur_col);
        cur_col++;
        if (cur_col >= COLS) begin
          cur_col = 0;
          cur_row++;
        end
      end
      // Scroll: the old top row becomes the cleared bottom row
      if (cur_row >= ROWS) begin
        for (int c = 0; c < COLS; c++) screen_cells[top_offset * COLS + c] = '0;
        top_offset   = (top_offset + 1) % ROWS;
        cur_row      = ROWS - 1;
        res.scrolled = 1'b1;
      end
    end
    res.cursor_row = ROW_PORT_W'(cur_row);
    res.cursor_col = COL_PORT_W'(cur_col);
    return res;
  endfunction

  task automatic check_field(string fname, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%0h actual 0x%0h", $time, fname, want, got);
      errs++;
    end
  endtask

  // Track config and command beats, compare each result beat
  always @(posedge clk) begin
    console_result_t want;
    if (rst) begin
      for (int i = 0; i < ROWS*COLS; i++) screen_cells[i] = '0;
      cur_row    = 0;
      cur_col    = 0;
      top_offset = 0;
      text_attr  = ATTR_RESET;
      console_results_q.delete();
    end else begin
      if (cfg_write) text_attr = cfg_data;
      if (done) begin
        if (console_results_q.size() == 0) begin
          $display("%0t: result beat with nothing expected", $time);
          errs++;
        end else begin
          want = console_results_q.pop_front();
          check_field("cell_written", 8'(want.cell_written), 8'(cell_written));
          check_field("written_row", 8'(want.written_row), 8'(written_row));
          check_field("written_col", 8'(want.written_col), 8'(written_col));
          check_field("scrolled", 8'(want.scrolled), 8'(scrolled));
          check_field("cursor_row_out", 8'(want.cursor_row), 8'(cursor_row_out));
          check_field("cursor_col_out", 8'(want.cursor_col), 8'(cursor_col_out));
          check_field("read_char", want.read_char, read_char);
          check_field("read_attr", want.read_attr, read_attr);
        end
      end
      if (start && !busy)
        console_results_q.push_back(console_step(command, char_code, read_row, read_col));
    end
    pending <= console_results_q.size();
  end

endmodule

/* bench/text_console_cell_writer_tb.sv */
// Testbench top for the text console cell writer: stimulus and verdict.
module text_console_cell_writer_tb import tcw_pkg::*;;

  localparam int ROWS = 25;
  localparam int COLS = 80;
  localparam int PHASE_ITEMS = 220;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  command = CMD_PUT;
  logic [CHAR_W-1:0]     char_code = '0;
  logic [ROW_PORT_W-1:0] read_row = '0;
  logic [COL_PORT_W-1:0] read_col = '0;
  logic                  cfg_write = 1'b0;
  logic [ATTR_W-1:0]     cfg_data = '0;
  logic                  done;
  logic                  cell_written;
  logic [ROW_PORT_W-1:0] written_row;
  logic [COL_PORT_W-1:0] written_col;
  logic                  scrolled;
  logic [ROW_PORT_W-1:0] cursor_row_out;
  logic [COL_PORT_W-1:0] cursor_col_out;
  logic [CHAR_W-1:0]     read_char;
  logic [ATTR_W-1:0]     read_attr;
  int                    err_count;
  int                    pending;

  always #10 clk = ~clk;

  text_console_cell_writer #(.ROWS(ROWS), .COLS(COLS)) dut (.*);

  text_console_cell_writer_checker #(.ROWS(ROWS), .COLS(COLS)) checker_i (.*);

  // Present one command beat and hold it until taken; start stays high
  task automatic send_beat(logic cmd, logic [CHAR_W-1:0] ch,
                           logic [ROW_PORT_W-1:0] rrow, logic [COL_PORT_W-1:0] rcol);
    start     <= 1'b1;
    command   <= cmd;
    char_code <= ch;
    read_row  <= rrow;
    read_col  <= rcol;
    do @(posedge clk); while (busy);
  endtask

  task automatic put_char(logic [CHAR_W-1:0] ch);
    send_beat(CMD_PUT, ch, ROW_PORT_W'($urandom), COL_PORT_W'($urandom));
  endtask

  task automatic read_cell(int rrow, int rcol);
    send_beat(CMD_READ, CHAR_W'($urandom), ROW_PORT_W'(rrow), COL_PORT_W'(rcol));
  endtask

  // Drop start and hold off until every result has come back
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_attr(logic [ATTR_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    cfg_data  <= ATTR_W'($urandom);
  endtask

  // Random beat: mostly text with line breaks, some reads, some noise bytes
  task automatic random_beat(int newline_pct);
    int pick;
    int rrow;
    int rcol;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      rrow = ($urandom_range(0, 99) < 85) ? $urandom_range(0, ROWS-1) : $urandom_range(0, 31);
      rcol = ($urandom_range(0, 99) < 85) ? $urandom_range(0, COLS-1) : $urandom_range(0, 127);
      read_cell(rrow, rcol);
    end else if (pick < 22 + newline_pct) begin
      put_char(CH_NEWLINE);
    end else if (pick < 25 + newline_pct) begin
      put_char(CH_RETURN);
    end else if (pick < 31 + newline_pct) begin
      put_char(CHAR_W'($urandom_range(0, 255)));
    end else begin
      put_char(CHAR_W'($urandom_range(CH_PRINT_LO, CH_PRINT_HI)));
    end
  endtask

  initial begin
    int idle_pct [4]   = '{0, 50, 31, 50};
    int newline_pct [4] = '{10, 2, 6, 1};
    logic [ATTR_W-1:0] phase_attr [4];
    int gap;

    phase_attr = '{8'hFF, 8'h00, ATTR_W'($urandom), ATTR_W'($urandom)};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty cell, print range edges, ignored bytes, control bytes,
    // reads in and out of range
    read_cell(0, 0);
    put_char(8'h41);
    put_char(CH_PRINT_LO);
    put_char(CH_PRINT_HI);
    put_char(8'h1F);
    put_char(8'h7F);
    put_char(8'h00);
    put_char(8'hFF);
    put_char(8'h80);
    put_char(CH_RETURN);
    read_cell(0, 0);
    read_cell(0, 2);
    read_cell(ROWS-1, COLS-1);
    read_cell(ROWS, 0);
    read_cell(0, COLS);
    read_cell(31, 127);
    put_char(CH_NEWLINE);
    put_char(8'h5A);
    read_cell(1, 0);
    put_char(CH_NEWLINE);
    put_char(CH_RETURN);
    drain();

    // Random phases, each with its own attribute and newline rate; phases 1 and 3 share an idle percentage
    for (int ph = 0; ph < 4; ph++) begin
      write_attr(phase_attr[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_beat(newline_pct[ph]);
        if (n % 97 == 96) begin
          drain();
        end else if ($urandom_range(0, 99) < idle_pct[ph]) begin
          gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3);
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      drain();
    end

    repeat (COLS + 20) @(posedge clk);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
